// ----- hdl/qpe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, character codes and helper functions of the query parameter
// extractor.
// ----------------------------------------------------------------------------
package qpe_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [4:0] MAX_KEY = 5'd16;

   localparam int MAX_RES   = 4;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_VALUE = 2'd1,
      PH_SKIP  = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_KEY_LEN   = 2'd0,
      REG_KEY_LOW   = 2'd1,
      REG_KEY_HIGH  = 2'd2,
      REG_OUT_LIMIT = 2'd3
   } reg_idx_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic             found;
   } item_type;

   typedef struct packed {
      logic [1:0]                 last_idx;
      item_type [MAX_RES-1:0]     items;
   } bundle_type;

   typedef struct packed {
      logic [4:0]       key_len;
      logic [15:0][7:0] key;
      logic [8:0]       out_limit;
   } cfg_type;

   // returns {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] plain_char(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/qpe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_front
// Parses query bytes, matches the key, percent-decodes the value and hands
// the results of each byte to the queue as one bundle.
// ----------------------------------------------------------------------------
module qpe_front #(
   parameter int RAW_LIMIT = 511
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qpe_pkg::cfg_type     cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   input  wire logic                 q_full,
   output logic                      q_push,
   output qpe_pkg::bundle_type       q_data
);

   localparam int RAW_W = $clog2(RAW_LIMIT + 1);

   qpe_pkg::phase_type phase_ff, phase_in;
   logic [4:0]         name_count_ff, name_count_in;
   logic               name_mismatch_ff, name_mismatch_in;
   logic [1:0]         pending_ff, pending_in;
   logic [7:0]         held_ff, held_in;
   logic [RAW_W-1:0]   raw_count_ff, raw_count_in;
   logic [8:0]         out_count_ff, out_count_in;
   logic               match_found_ff, match_found_in;

   logic               fire;
   logic               is_amp;
   logic               is_eq;
   logic               key_hit;
   logic [4:0]         hx;
   logic [4:0]         hh;
   logic [3:0][7:0]    dec;
   logic [2:0]         n_dec;
   logic [8:0]         remaining;
   logic [2:0]         allowed;
   logic [2:0]         n_res;

   assign in_ready = !q_full;
   assign fire     = in_valid && in_ready;
   assign is_amp   = (in_byte == qpe_pkg::CHAR_AMP);
   assign is_eq    = (in_byte == qpe_pkg::CHAR_EQ);
   assign key_hit  = !match_found_ff && !name_mismatch_ff &&
                     (cfg.key_len <= qpe_pkg::MAX_KEY) &&
                     (name_count_ff == cfg.key_len);
   assign hx       = qpe_pkg::hex_digit(in_byte);
   assign hh       = qpe_pkg::hex_digit(held_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            qpe_pkg::PH_NAME: begin
               if (is_eq) begin
                  phase_in = key_hit ? qpe_pkg::PH_VALUE : qpe_pkg::PH_SKIP;
               end
            end
            qpe_pkg::PH_SKIP: begin
               if (is_amp) begin
                  phase_in = qpe_pkg::PH_NAME;
               end
            end
            qpe_pkg::PH_VALUE: begin
               if (is_amp) begin
                  phase_in = qpe_pkg::PH_DONE;
               end
            end
            qpe_pkg::PH_DONE: begin
               phase_in = qpe_pkg::PH_DONE;
            end
         endcase
      end
   end

   // datapath and results
   always_comb begin
      name_count_in    = name_count_ff;
      name_mismatch_in = name_mismatch_ff;
      pending_in       = pending_ff;
      held_in          = held_ff;
      raw_count_in     = raw_count_ff;
      out_count_in     = out_count_ff;
      match_found_in   = match_found_ff;
      dec              = '0;
      n_dec            = 3'd0;
      remaining        = 9'd0;
      allowed          = 3'd0;
      n_res            = 3'd0;
      q_data           = '0;
      q_push           = 1'b0;

      if (fire) begin
         unique case (phase_ff)
            qpe_pkg::PH_NAME: begin
               if (is_amp) begin
                  name_count_in    = 5'd0;
                  name_mismatch_in = 1'b0;
               end else if (is_eq) begin
                  if (key_hit) begin
                     match_found_in = 1'b1;
                     raw_count_in   = '0;
                     out_count_in   = 9'd0;
                     pending_in     = 2'd0;
                  end
               end else begin
                  if (cfg.key_len > qpe_pkg::MAX_KEY || name_count_ff >= cfg.key_len ||
                      in_byte != cfg.key[name_count_ff[3:0]]) begin
                     name_mismatch_in = 1'b1;
                  end
                  if (name_count_ff != 5'd31) begin
                     name_count_in = name_count_ff + 5'd1;
                  end
               end
            end
            qpe_pkg::PH_SKIP: begin
               if (is_amp) begin
                  name_count_in    = 5'd0;
                  name_mismatch_in = 1'b0;
               end
            end
            qpe_pkg::PH_VALUE: begin
               if (is_amp) begin
                  if (pending_ff != 2'd0) begin
                     dec[n_dec[1:0]] = qpe_pkg::CHAR_PCT;
                     n_dec = n_dec + 3'd1;
                  end
                  if (pending_ff == 2'd2) begin
                     dec[n_dec[1:0]] = held_ff;
                     n_dec = n_dec + 3'd1;
                  end
                  pending_in = 2'd0;
               end else if (raw_count_ff < RAW_W'(RAW_LIMIT)) begin
                  raw_count_in = raw_count_ff + RAW_W'(1);
                  unique case (pending_ff)
                     2'd0: begin
                        if (in_byte == qpe_pkg::CHAR_PCT) begin
                           pending_in = 2'd1;
                        end else begin
                           dec[n_dec[1:0]] = qpe_pkg::plain_char(in_byte);
                           n_dec = n_dec + 3'd1;
                        end
                     end
                     2'd1: begin
                        if (hx[4]) begin
                           held_in    = in_byte;
                           pending_in = 2'd2;
                        end else begin
                           dec[n_dec[1:0]] = qpe_pkg::CHAR_PCT;
                           n_dec = n_dec + 3'd1;
                           pending_in = 2'd0;
                           if (in_byte == qpe_pkg::CHAR_PCT) begin
                              pending_in = 2'd1;
                           end else begin
                              dec[n_dec[1:0]] = qpe_pkg::plain_char(in_byte);
                              n_dec = n_dec + 3'd1;
                           end
                        end
                     end
                     default: begin
                        pending_in = 2'd0;
                        if (hx[4]) begin
                           dec[n_dec[1:0]] = {hh[3:0], hx[3:0]};
                           n_dec = n_dec + 3'd1;
                        end else begin
                           dec[n_dec[1:0]] = qpe_pkg::CHAR_PCT;
                           n_dec = n_dec + 3'd1;
                           dec[n_dec[1:0]] = held_ff;
                           n_dec = n_dec + 3'd1;
                           if (in_byte == qpe_pkg::CHAR_PCT) begin
                              pending_in = 2'd1;
                           end else begin
                              dec[n_dec[1:0]] = qpe_pkg::plain_char(in_byte);
                              n_dec = n_dec + 3'd1;
                           end
                        end
                     end
                  endcase
               end
            end
            qpe_pkg::PH_DONE: begin
               pending_in = pending_ff;
            end
         endcase

         // flush a pending escape at the end of the query
         if (in_last && phase_in == qpe_pkg::PH_VALUE) begin
            if (pending_in != 2'd0) begin
               dec[n_dec[1:0]] = qpe_pkg::CHAR_PCT;
               n_dec = n_dec + 3'd1;
            end
            if (pending_in == 2'd2 && n_dec != 3'd4) begin
               dec[n_dec[1:0]] = held_in;
               n_dec = n_dec + 3'd1;
            end
            pending_in = 2'd0;
         end

         // output limit
         if (out_count_ff < cfg.out_limit) begin
            remaining = cfg.out_limit - out_count_ff;
         end
         allowed = (remaining >= {6'd0, n_dec}) ? n_dec : remaining[2:0];
         if (n_dec != 3'd0) begin
            out_count_in = out_count_ff + {6'd0, allowed};
         end

         for (int i = 0; i < qpe_pkg::MAX_RES; i++) begin
            if (3'(i) < allowed) begin
               q_data.items[i] = '{kind: qpe_pkg::KIND_DATA, data: dec[i], found: 1'b1};
            end
         end
         n_res = allowed;
         if (in_last && allowed != 3'd4) begin
            q_data.items[allowed[1:0]] = '{kind: qpe_pkg::KIND_SUMMARY, data: 8'd0,
                                           found: match_found_in};
            n_res = allowed + 3'd1;
         end
         q_data.last_idx = 2'(n_res - 3'd1);
         q_push          = (n_res != 3'd0);

         if (in_last) begin
            name_count_in    = 5'd0;
            name_mismatch_in = 1'b0;
            pending_in       = 2'd0;
            held_in          = 8'd0;
            raw_count_in     = '0;
            out_count_in     = 9'd0;
            match_found_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= qpe_pkg::PH_NAME;
         name_count_ff    <= 5'd0;
         name_mismatch_ff <= 1'b0;
         pending_ff       <= 2'd0;
         held_ff          <= 8'd0;
         raw_count_ff     <= '0;
         out_count_ff     <= 9'd0;
         match_found_ff   <= 1'b0;
      end else begin
         phase_ff         <= (fire && in_last) ? qpe_pkg::PH_NAME : phase_in;
         name_count_ff    <= name_count_in;
         name_mismatch_ff <= name_mismatch_in;
         pending_ff       <= pending_in;
         held_ff          <= held_in;
         raw_count_ff     <= raw_count_in;
         out_count_ff     <= out_count_in;
         match_found_ff   <= match_found_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/qpe_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_queue
// Short bundle queue between the parsing front and the result back end.
// ----------------------------------------------------------------------------
module qpe_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire qpe_pkg::bundle_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output qpe_pkg::bundle_type       head_data
);

   localparam int PTR_W = $clog2(qpe_pkg::QUEUE_DEPTH);

   qpe_pkg::bundle_type  store_ff [qpe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == (PTR_W+1)'(qpe_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/qpe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qpe_back
// Takes bundles from the queue and sends their results one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module qpe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire qpe_pkg::bundle_type  q_data,
   output logic                      q_pop,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output qpe_pkg::item_type         out_item,
   output logic                      out_last
);

   qpe_pkg::bundle_type  cur_ff, cur_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic                 done_word;

   assign out_valid = valid_ff;
   assign out_item  = cur_ff.items[idx_ff];
   assign out_last  = (idx_ff == cur_ff.last_idx);
   assign done_word = valid_ff && out_ready && out_last;
   assign q_pop     = q_valid && (!valid_ff || done_word);

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (q_pop) begin
         cur_in   = q_data;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (done_word) begin
         valid_in = 1'b0;
      end else if (valid_ff && out_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/query_parameter_extractor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// query_parameter_extractor_core
// Finds a configured key in a URL query stream and emits the percent-decoded
// value bytes plus an end-of-query summary word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | tvalid/tready          | tdata query_byte, tlast end_of_query
//  rsp     | out | tvalid/tready          | tdata out_byte/found, tuser out_kind,
//          |     |                        | tlast run_last
//  csr     | in  | psel/penable/pwrite    | key_len, key_low, key_high, out_limit
//
//  one query byte is taken per cycle; a byte can yield up to four result words,
//  which the result side sends one at a time, and the four-entry bundle queue
//  between the parser and the result register absorbs such bursts
//  req_tready drops only while that queue is full
//  reset is synchronous and returns the parser to the start of a new query
// ----------------------------------------------------------------------------
module query_parameter_extractor_core #(
   parameter int RAW_LIMIT = 511
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] query_byte
   input  wire logic        req_tlast,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // [7:0] out_byte, [8] found, zero fill
   output logic             rsp_tuser,     // [0] out_kind
   output logic             rsp_tlast,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   logic [4:0]           key_len_ff;
   logic [63:0]          key_low_ff;
   logic [63:0]          key_high_ff;
   logic [8:0]           out_limit_ff;
   logic                 csr_write;
   qpe_pkg::reg_idx_type csr_idx;
   qpe_pkg::cfg_type     cfg;

   logic                 q_full;
   logic                 q_push;
   qpe_pkg::bundle_type  q_push_data;
   logic                 q_pop;
   logic                 q_not_empty;
   qpe_pkg::bundle_type  q_head;
   qpe_pkg::item_type    out_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = qpe_pkg::reg_idx_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff   <= 5'd0;
         key_low_ff   <= 64'd0;
         key_high_ff  <= 64'd0;
         out_limit_ff <= 9'd511;
      end else if (csr_write) begin
         unique case (csr_idx)
            qpe_pkg::REG_KEY_LEN:   key_len_ff   <= csr_pwdata[4:0];
            qpe_pkg::REG_KEY_LOW:   key_low_ff   <= csr_pwdata;
            qpe_pkg::REG_KEY_HIGH:  key_high_ff  <= csr_pwdata;
            qpe_pkg::REG_OUT_LIMIT: out_limit_ff <= csr_pwdata[8:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         qpe_pkg::REG_KEY_LEN:   csr_prdata = {59'd0, key_len_ff};
         qpe_pkg::REG_KEY_LOW:   csr_prdata = key_low_ff;
         qpe_pkg::REG_KEY_HIGH:  csr_prdata = key_high_ff;
         qpe_pkg::REG_OUT_LIMIT: csr_prdata = {55'd0, out_limit_ff};
      endcase
   end

   assign cfg = '{key_len: key_len_ff, key: {key_high_ff, key_low_ff},
                  out_limit: out_limit_ff};

   qpe_front #(
      .RAW_LIMIT (RAW_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   qpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   qpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, out_item.found, out_item.data};
   assign rsp_tuser = out_item.kind;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the query parameter extractor core. Query bytes are
// streamed in with random gaps and random result-side stalls. A behavioral
// decoder inside the bench predicts the decoded value words and the
// end-of-query summary word for every accepted byte. Each result word is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RAW_CAP        = 511;
   localparam int STALL_CYCLES   = 60;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 10;

   typedef logic [15:0][7:0] key_type;

   typedef struct {
      qpe_pkg::kind_type kind;
      logic [7:0]        data;
      logic              found;
      logic              last;
   } result_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] query_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;     // [7:0] out_byte, [8] found, zero fill
   logic        rsp_tuser;     // [0] out_kind
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // decoder model: settings and per-query state
   logic [4:0]          key_length;
   key_type             key_bytes;
   logic [8:0]          emit_limit;
   qpe_pkg::phase_type  scan_phase;
   logic [4:0]          name_seen;
   logic                name_differs;
   logic [1:0]          pct_state;
   logic [7:0]          held_hex;
   logic [8:0]          raw_taken;
   logic [8:0]          bytes_out;
   logic                key_matched;
   result_word_type     byte_words[$];
   result_word_type     words_due[$];

   logic [7:0]   query_bytes[$];
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           bytes_sent = 0;
   bit           stall_request = 1'b0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;

   query_parameter_extractor_core #(
      .RAW_LIMIT(RAW_CAP)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void start_query();
      scan_phase   = qpe_pkg::PH_NAME;
      name_seen    = '0;
      name_differs = 1'b0;
      pct_state    = 2'd0;
      held_hex     = 8'h00;
      raw_taken    = '0;
      bytes_out    = '0;
      key_matched  = 1'b0;
   endfunction

   function automatic void reset_model();
      key_length = '0;
      key_bytes  = '0;
      emit_limit = 9'd511;
      start_query();
      words_due.delete();
   endfunction

   function automatic void apply_register(qpe_pkg::reg_idx_type idx, logic [63:0] value);
      case (idx)
         qpe_pkg::REG_KEY_LEN:   key_length = value[4:0];
         qpe_pkg::REG_KEY_LOW:   key_bytes[7:0] = value;
         qpe_pkg::REG_KEY_HIGH:  key_bytes[15:8] = value;
         qpe_pkg::REG_OUT_LIMIT: emit_limit = value[8:0];
         default: ;
      endcase
   endfunction

   function automatic void add_word(qpe_pkg::kind_type kind, logic [7:0] data,
                                    logic found);
      result_word_type w;
      if (byte_words.size() < qpe_pkg::MAX_RES) begin
         w.kind  = kind;
         w.data  = data;
         w.found = found;
         w.last  = 1'b0;
         byte_words.push_back(w);
      end
   endfunction

   function automatic void emit_decoded(logic [7:0] data);
      if (bytes_out < emit_limit) begin
         add_word(qpe_pkg::KIND_DATA, data, 1'b1);
         bytes_out++;
      end
   endfunction

   function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         nib = c[3:0];
         return 1'b1;
      end
      // low nibble of a-f and A-F is 1..6
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         nib = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void decode_plain(logic [7:0] b);
      if (b == qpe_pkg::CHAR_PCT) begin
         pct_state = 2'd1;
      end else begin
         emit_decoded((b == qpe_pkg::CHAR_PLUS) ? qpe_pkg::CHAR_SPACE : b);
      end
   endfunction

   function automatic void decode_value(logic [7:0] b);
      logic [3:0] lo;
      logic [3:0] hi;
      logic       is_hex;
      is_hex = hex_nibble(b, lo);
      case (pct_state)
         2'd0: decode_plain(b);
         2'd1: begin
            if (is_hex) begin
               held_hex  = b;
               pct_state = 2'd2;
            end else begin
               pct_state = 2'd0;
               emit_decoded(qpe_pkg::CHAR_PCT);
               decode_plain(b);
            end
         end
         default: begin
            pct_state = 2'd0;
            if (is_hex) begin
               void'(hex_nibble(held_hex, hi));
               emit_decoded({hi, lo});
            end else begin
               emit_decoded(qpe_pkg::CHAR_PCT);
               emit_decoded(held_hex);
               decode_plain(b);
            end
         end
      endcase
   endfunction

   function automatic void flush_pct();
      if (pct_state != 2'd0) emit_decoded(qpe_pkg::CHAR_PCT);
      if (pct_state == 2'd2) emit_decoded(held_hex);
      pct_state = 2'd0;
   endfunction

   function automatic void predict_from_byte(logic [7:0] b, logic eoq);
      result_word_type w;
      byte_words.delete();
      case (scan_phase)
         qpe_pkg::PH_NAME: begin
            if (b == qpe_pkg::CHAR_AMP) begin
               name_seen    = '0;
               name_differs = 1'b0;
            end else if (b == qpe_pkg::CHAR_EQ) begin
               if (!key_matched && !name_differs && key_length <= qpe_pkg::MAX_KEY &&
                   name_seen == key_length) begin
                  key_matched = 1'b1;
                  scan_phase  = qpe_pkg::PH_VALUE;
                  raw_taken   = '0;
                  bytes_out   = '0;
                  pct_state   = 2'd0;
               end else begin
                  scan_phase = qpe_pkg::PH_SKIP;
               end
            end else begin
               if (key_length > qpe_pkg::MAX_KEY || name_seen >= key_length ||
                   b != key_bytes[name_seen[3:0]])
                  name_differs = 1'b1;
               if (name_seen != 5'd31) name_seen++;
            end
         end
         qpe_pkg::PH_SKIP: begin
            if (b == qpe_pkg::CHAR_AMP) begin
               scan_phase   = qpe_pkg::PH_NAME;
               name_seen    = '0;
               name_differs = 1'b0;
            end
         end
         qpe_pkg::PH_VALUE: begin
            if (b == qpe_pkg::CHAR_AMP) begin
               flush_pct();
               scan_phase = qpe_pkg::PH_DONE;
            end else if (raw_taken < RAW_CAP) begin
               raw_taken++;
               decode_value(b);
            end
         end
         default: ;
      endcase
      if (eoq) begin
         if (scan_phase == qpe_pkg::PH_VALUE) flush_pct();
         add_word(qpe_pkg::KIND_SUMMARY, 8'h00, key_matched);
         start_query();
      end
      foreach (byte_words[i]) begin
         w      = byte_words[i];
         w.last = (i == byte_words.size() - 1);
         words_due.push_back(w);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // prediction, checking and watchdog
   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         reset_model();
         quiet_cycles = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_register(qpe_pkg::reg_idx_type'(csr_paddr[4:3]), csr_pwdata);
         if (req_tvalid && req_tready) predict_from_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (words_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 16'h0000);
            end else begin
               want = words_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("out_kind", rsp_tuser, want.kind);
               if (rsp_tdata[7:0] !== want.data)
                  report_mismatch("out_byte", rsp_tdata[7:0], want.data);
               if (rsp_tdata[8] !== want.found)
                  report_mismatch("found", rsp_tdata[8], want.found);
               if (rsp_tdata[15:9] !== 7'd0)
                  report_mismatch("tdata fill", rsp_tdata, {7'd0, want.found, want.data});
               if (rsp_tlast !== want.last)
                  report_mismatch("run_last", rsp_tlast, want.last);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // result side: random stalls per word, one long hold on request
   initial begin : rsp_sink
      int wait_n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            rsp_tready <= 1'b0;
            for (int n = 0; n < STALL_CYCLES; n++) @(negedge clock);
            stall_request = 1'b0;
         end
         wait_n = rsp_idle_on ? $urandom_range(0, 4) : 0;
         repeat (wait_n) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eoq);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoq;
      do @(posedge clock); while (req_tready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic close_query);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], close_query && (i == s.len() - 1));
   endtask

   task automatic send_query_bytes();
      foreach (query_bytes[i]) send_byte(query_bytes[i], i == query_bytes.size() - 1);
   endtask

   task automatic write_register(input qpe_pkg::reg_idx_type idx,
                                 input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // input idle, all words drained, then let the pipeline settle
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_settings(input logic [4:0] klen, input key_type kb,
                                input logic [8:0] lim);
      wait_quiet();
      write_register(qpe_pkg::REG_KEY_LEN, {59'd0, klen});
      write_register(qpe_pkg::REG_KEY_LOW, kb[7:0]);
      write_register(qpe_pkg::REG_KEY_HIGH, kb[15:8]);
      write_register(qpe_pkg::REG_OUT_LIMIT, {55'd0, lim});
   endtask

   function automatic key_type key_from_text(input string s);
      key_type kb;
      kb = '0;
      for (int i = 0; i < s.len() && i < 16; i++) kb[i] = s[i];
      return kb;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_value_byte();
      string hex_chars;
      hex_chars = "0123456789abcdefABCDEF";
      case ($urandom_range(0, 9))
         0, 1, 2: return hex_chars[$urandom_range(0, 21)];
         3, 4:    return qpe_pkg::CHAR_PCT;
         5:       return qpe_pkg::CHAR_PLUS;
         6, 7:    return rand_letter();
         8:       return 8'($urandom_range(0, 255));
         default: return $urandom_range(0, 1) ? qpe_pkg::CHAR_AMP : qpe_pkg::CHAR_EQ;
      endcase
   endfunction

   function automatic void append_value();
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      repeat (len) query_bytes.push_back(rand_value_byte());
   endfunction

   function automatic void append_segment();
      int choice;
      int start;
      int pos;
      choice = $urandom_range(0, 9);
      start  = query_bytes.size();
      case (choice)
         0, 1, 2, 3, 4, 5: begin
            for (int i = 0; i < key_length; i++) query_bytes.push_back(key_bytes[i % 16]);
            // near miss of the key name
            if (choice >= 4) begin
               case ($urandom_range(0, 2))
                  0: begin
                     if (key_length != 0) begin
                        pos = start + $urandom_range(0, key_length - 1);
                        query_bytes[pos] = query_bytes[pos] + 8'd1;
                     end
                  end
                  1: query_bytes.push_back(rand_letter());
                  default: if (query_bytes.size() > start) void'(query_bytes.pop_back());
               endcase
            end
            query_bytes.push_back(qpe_pkg::CHAR_EQ);
            append_value();
         end
         6: repeat ($urandom_range(0, 3)) query_bytes.push_back(rand_letter());
         7: begin
            query_bytes.push_back(qpe_pkg::CHAR_EQ);
            append_value();
         end
         8: repeat ($urandom_range(1, 6)) query_bytes.push_back(8'($urandom_range(0, 255)));
         default: begin
            repeat ($urandom_range(1, 4)) query_bytes.push_back(rand_letter());
            query_bytes.push_back(qpe_pkg::CHAR_EQ);
            append_value();
         end
      endcase
   endfunction

   function automatic void build_random_query();
      int nseg;
      query_bytes.delete();
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
         if (s > 0) query_bytes.push_back(qpe_pkg::CHAR_AMP);
         append_segment();
      end
      if ($urandom_range(0, 7) == 0) query_bytes.push_back(qpe_pkg::CHAR_AMP);
      if (query_bytes.size() == 0) query_bytes.push_back(rand_letter());
   endfunction

   // reset settings: empty key, digit left pending at the end of the query
   task automatic test_empty_key();
      send_text("=%4", 1'b1);
   endtask

   // segment without '=', escapes, plus, bad escape, pending escape at '&'
   task automatic test_segment_rules();
      load_settings(5'd2, key_from_text("ab"), 9'd511);
      send_text("a&ab=%41+%g%", 1'b1);
      send_text("ab=%4&b", 1'b1);
   endtask

   // output limit, all-ones key with a zero byte, key longer than supported
   task automatic test_limits();
      key_type kb;
      load_settings(5'd2, key_from_text("ab"), 9'd2);
      send_text("ab=%4x", 1'b1);
      kb    = '1;
      kb[1] = 8'h00;
      load_settings(5'd2, kb, 9'd511);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(qpe_pkg::CHAR_EQ, 1'b0);
      send_byte(8'h80, 1'b1);
      load_settings(5'd20, kb, 9'd511);
      send_text("=q", 1'b1);
   endtask

   // value truncated with an escape pending at the raw cut
   task automatic test_raw_limit();
      load_settings(5'd0, '0, 9'd511);
      send_byte(qpe_pkg::CHAR_EQ, 1'b0);
      for (int i = 0; i < RAW_CAP - 1; i++) send_byte(rand_letter(), 1'b0);
      send_byte(qpe_pkg::CHAR_PCT, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h31, 1'b1);
   endtask

   // long result-side hold while bytes keep coming
   task automatic test_backpressure();
      load_settings(5'd0, '0, 9'd511);
      req_idle_on   = 1'b0;
      stall_request = 1'b1;
      send_byte(qpe_pkg::CHAR_EQ, 1'b0);
      for (int n = 0; n < 40; n++)
         send_byte((n % 4 == 0) ? qpe_pkg::CHAR_PCT : 8'h67 + 8'($urandom_range(0, 19)),
                   1'b0);
      send_byte(8'h7A, 1'b1);
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_queries();
      key_type kb;
      int      klen;
      int      lim;
      int      phase_start;
      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < 16; i++)
            kb[i] = (p == 0) ? 8'($urandom_range(0, 255)) : rand_letter();
         case (p)
            0: begin klen = 16; lim = 511; end
            1: begin klen = 1; lim = 0; end
            2: begin klen = $urandom_range(2, 8); lim = $urandom_range(1, 4); end
            3: begin klen = $urandom_range(17, 31); lim = 511; end
            4: begin klen = 0; lim = $urandom_range(5, 40); end
            default: begin klen = $urandom_range(1, 16); lim = $urandom_range(41, 511); end
         endcase
         load_settings(5'(klen), kb, 9'(lim));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_random_query();
            send_query_bytes();
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_key();
      test_segment_rules();
      test_limits();
      test_raw_limit();
      test_backpressure();
      test_random_queries();

      wait_quiet();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
